FILE: hw/rtl/assembly_line_to_opcode_core_defines.svh
// assertion helpers shared by the queue and emitter rtl files
`ifndef ASSEMBLY_LINE_TO_OPCODE_CORE_DEFINES_SVH
`define ASSEMBLY_LINE_TO_OPCODE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ALO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ALO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/alo_pkg.sv
package alo_pkg;

  localparam int MNEMONIC_COUNT = 56;
  localparam int MODE_COLUMNS   = 11;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [7:0]  OPC_NONE   = 8'hFF;
  localparam logic [15:0] LOC_MAX_2B = 16'd65534;
  localparam logic [15:0] LOC_MAX_3B = 16'd65533;

  // addressing mode columns of the opcode table
  typedef enum logic [3:0] {
    COL_IMM  = 4'd0,
    COL_ABS  = 4'd1,
    COL_ABX  = 4'd2,
    COL_ABY  = 4'd3,
    COL_ZP   = 4'd4,
    COL_ZPX  = 4'd5,
    COL_ZPY  = 4'd6,
    COL_IDX  = 4'd7,
    COL_IDY  = 4'd8,
    COL_IND  = 4'd9,
    COL_IMP  = 4'd10,
    COL_NONE = 4'd15
  } col_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_SYNTAX = 2'd1,
    ERR_OPCODE = 2'd2,
    ERR_MEMORY = 2'd3
  } err_t;

  // one classified line, handed from the parser to the emitter
  typedef struct packed {
    logic [23:0] letters;
    logic        len_ok;
    col_t        col;
    logic [1:0]  size;
    logic        syn_err;
    logic [15:0] operand;
  } line_rec_t;

  localparam logic [23:0] MNEM_KEYS [MNEMONIC_COUNT] = '{
    "ADC", "AND", "ASL", "BCC", "BCS", "BEQ", "BIT", "BMI", "BNE", "BPL", "BRK", "BVC",
    "BVS", "CLC", "CLD", "CLI", "CLV", "CMP", "CPX", "CPY", "DEC", "DEX", "DEY", "EOR",
    "INC", "INX", "INY", "JMP", "JSR", "LDA", "LDX", "LDY", "LSR", "NOP", "ORA", "PHA",
    "PHP", "PLA", "PLP", "ROL", "ROR", "RTI", "RTS", "SBC", "SEC", "SED", "SEI", "STA",
    "STX", "STY", "TAX", "TAY", "TSX", "TXA", "TXS", "TYA"
  };

  // columns: imm abs abx aby zp zpx zpy idx idy ind imp
  localparam logic [7:0] OPCODE_TABLE [MNEMONIC_COUNT][MODE_COLUMNS] = '{
    '{8'h69,8'h6D,8'h7D,8'h79,8'h65,8'h75,8'hFF,8'h61,8'h71,8'hFF,8'hFF},
    '{8'h29,8'h2D,8'h3D,8'h39,8'h25,8'h35,8'hFF,8'h21,8'h31,8'hFF,8'hFF},
    '{8'hFF,8'h0E,8'h1E,8'hFF,8'h06,8'h16,8'hFF,8'hFF,8'hFF,8'hFF,8'h0A},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'h90,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hB0,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hF0,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'h2C,8'hFF,8'hFF,8'h24,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'h30,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hD0,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'h10,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h00},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'h50,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'h70,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h18},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hD8},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h58},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hB8},
    '{8'hC9,8'hCD,8'hDD,8'hD9,8'hC5,8'hD5,8'hFF,8'hC1,8'hD1,8'hFF,8'hFF},
    '{8'hE0,8'hEC,8'hFF,8'hFF,8'hE4,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hC0,8'hCC,8'hFF,8'hFF,8'hC4,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'hCE,8'hDE,8'hFF,8'hC6,8'hD6,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hCA},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h88},
    '{8'h49,8'h4D,8'h5D,8'h59,8'h45,8'h55,8'hFF,8'h41,8'h51,8'hFF,8'hFF},
    '{8'hFF,8'hEE,8'hFE,8'hFF,8'hE6,8'hF6,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hE8},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hC8},
    '{8'hFF,8'h4C,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h6C,8'hFF},
    '{8'hFF,8'h20,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hA9,8'hAD,8'hBD,8'hB9,8'hA5,8'hB5,8'hFF,8'hA1,8'hB1,8'hFF,8'hFF},
    '{8'hA2,8'hAE,8'hFF,8'hBE,8'hA6,8'hFF,8'hB6,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hA0,8'hAC,8'hBC,8'hFF,8'hA4,8'hB4,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'h4E,8'h5E,8'hFF,8'h46,8'h56,8'hFF,8'hFF,8'hFF,8'hFF,8'h4A},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hEA},
    '{8'h09,8'h0D,8'h1D,8'h19,8'h05,8'h15,8'hFF,8'h01,8'h11,8'hFF,8'hFF},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h48},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h08},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h68},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h28},
    '{8'hFF,8'h2E,8'h3E,8'hFF,8'h26,8'h36,8'hFF,8'hFF,8'hFF,8'hFF,8'h2A},
    '{8'hFF,8'h6E,8'h7E,8'hFF,8'h66,8'h76,8'hFF,8'hFF,8'hFF,8'hFF,8'h6A},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h40},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h60},
    '{8'hE9,8'hED,8'hFD,8'hF9,8'hE5,8'hF5,8'hFF,8'hE1,8'hF1,8'hFF,8'hFF},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h38},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hF8},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h78},
    '{8'hFF,8'h8D,8'h9D,8'h99,8'h85,8'h95,8'hFF,8'h81,8'h91,8'hFF,8'hFF},
    '{8'hFF,8'h8E,8'hFF,8'hFF,8'h86,8'hFF,8'h96,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'h8C,8'hFF,8'hFF,8'h84,8'h94,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hAA},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hA8},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hBA},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h8A},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h9A},
    '{8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h98}
  };

endpackage

FILE: hw/rtl/alo_front.sv
module alo_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  char_valid,
  input  logic [7:0]            char_code,
  output logic                  rec_push,
  output alo_pkg::line_rec_t    rec
);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_UY     = 8'h59;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_LY     = 8'h79;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] NOT_DIGIT = 8'd99;
  localparam logic [2:0] LEN_SAT   = 3'd4;
  localparam logic [2:0] LEN_KEY   = 3'd3;

  typedef enum logic [7:0] {
    PH_LEAD    = 8'b0000_0001,
    PH_MNEM    = 8'b0000_0010,
    PH_GAP     = 8'b0000_0100,
    PH_SWITCH  = 8'b0000_1000,
    PH_SKIP    = 8'b0001_0000,
    PH_OPERAND = 8'b0010_0000,
    PH_INDEX   = 8'b0100_0000,
    PH_TAIL    = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic immed;
    logic hex;
    logic bin;
    logic dec;
    logic paren;
    logic comma;
    logic indir;
    logic idxind;
    logic indidx;
    logic yreg;
    logic xreg;
    logic pass2;
    logic stop;
  } mark_t;

  typedef struct packed {
    phase_t      phase;
    mark_t       marks;
    logic [16:0] acc;
  } pstate_t;

  function automatic phase_t after_mark(mark_t m);
    return m.pass2 ? PH_INDEX : PH_OPERAND;
  endfunction

  // one digit into the operand, base from the marks
  function automatic pstate_t add_digit(pstate_t s, logic [7:0] c);
    pstate_t     r;
    logic [7:0]  base;
    logic [7:0]  d;
    logic [20:0] lo;
    logic [20:0] nx;
    r  = s;
    lo = {5'd0, s.acc[15:0]};
    if (s.marks.dec) begin
      base = 8'd10;
    end else if (s.marks.bin) begin
      base = 8'd2;
    end else if (s.marks.hex) begin
      base = 8'd16;
    end else begin
      base = 8'd0;
    end
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA + 8'd10;
    end else begin
      d = NOT_DIGIT;
    end
    case (base)
      8'd10:   nx = (lo << 3) + (lo << 1);
      8'd2:    nx = lo << 1;
      default: nx = lo << 4;
    endcase
    nx = nx + {13'd0, d};
    if (!s.marks.stop && base != 8'd0) begin
      if (d >= base) begin
        r.marks.stop = 1'b1;
      end else begin
        r.acc = {s.acc[16] | (nx[20:16] != 5'd0), nx[15:0]};
      end
    end
    return r;
  endfunction

  function automatic pstate_t check_index(pstate_t s, logic [7:0] c);
    pstate_t r;
    r = s;
    if (c == CH_UX || c == CH_LX) r.marks.xreg = 1'b1;
    if (c == CH_UY || c == CH_LY) r.marks.yreg = 1'b1;
    r.phase = PH_TAIL;
    return r;
  endfunction

  function automatic pstate_t do_switch(pstate_t s, logic [7:0] c);
    pstate_t r;
    r = s;
    if (c == CH_HASH) begin
      r.marks.immed = 1'b1;
      r.marks.hex   = 1'b1;
      r.phase       = PH_SKIP;
    end else if (c == CH_DOLLAR) begin
      r.marks.hex = 1'b1;
      r.phase     = after_mark(s.marks);
    end else if (c == CH_PCT) begin
      r.marks.bin = 1'b1;
      r.phase     = after_mark(s.marks);
    end else if (c == CH_COMMA) begin
      if (s.marks.indir && s.marks.paren) r.marks.idxind = 1'b1;
      if (s.marks.indir && !s.marks.paren) r.marks.indidx = 1'b1;
      r.marks.comma = 1'b1;
      r.phase       = after_mark(s.marks);
    end else begin
      r.marks.dec = 1'b1;
      if (s.marks.pass2) begin
        r = check_index(r, c);
      end else begin
        r.phase = PH_OPERAND;
        r = add_digit(r, c);
      end
    end
    return r;
  endfunction

  function automatic pstate_t do_entry(pstate_t s, logic [7:0] c);
    pstate_t r;
    r = s;
    if (c == CH_LPAREN) begin
      r.marks.paren = 1'b1;
      r.marks.indir = 1'b1;
      r.phase       = PH_SWITCH;
    end else if (c == CH_RPAREN) begin
      r.marks.paren = 1'b0;
      r.phase       = PH_SWITCH;
    end else begin
      r = do_switch(s, c);
    end
    return r;
  endfunction

  pstate_t     st_r, st_nxt;
  logic [23:0] letters_r, letters_nxt;
  logic [2:0]  len_r, len_nxt;
  logic        line_end;
  logic        add_let;
  logic [7:0]  folded;

  assign line_end = (char_code == CH_NUL) || (char_code == CH_LF);
  assign folded   = (char_code >= CH_LA && char_code <= CH_LZ) ? char_code - 8'd32 : char_code;

  // per-character parse step
  always_comb begin
    st_nxt  = st_r;
    add_let = 1'b0;
    case (st_r.phase)
      PH_LEAD: begin
        if (char_code != CH_SPACE) begin
          add_let      = 1'b1;
          st_nxt.phase = PH_MNEM;
        end
      end
      PH_MNEM: begin
        if (char_code == CH_SPACE) st_nxt.phase = PH_GAP;
        else add_let = 1'b1;
      end
      PH_GAP: begin
        if (char_code != CH_SPACE) st_nxt = do_entry(st_r, char_code);
      end
      PH_SWITCH: st_nxt = do_switch(st_r, char_code);
      PH_SKIP:   st_nxt.phase = after_mark(st_r.marks);
      PH_OPERAND: begin
        if (char_code == CH_COMMA || char_code == CH_RPAREN) begin
          st_nxt.marks.pass2 = 1'b1;
          st_nxt = do_entry(st_nxt, char_code);
        end else begin
          st_nxt = add_digit(st_r, char_code);
        end
      end
      PH_INDEX: st_nxt = check_index(st_r, char_code);
      default:  st_nxt = st_r;
    endcase
  end

  // mnemonic letter capture
  always_comb begin
    letters_nxt = letters_r;
    len_nxt     = len_r;
    if (add_let) begin
      case (len_r)
        3'd0:    letters_nxt[23:16] = folded;
        3'd1:    letters_nxt[15:8]  = folded;
        3'd2:    letters_nxt[7:0]   = folded;
        default: letters_nxt        = letters_r;
      endcase
      if (len_r < LEN_SAT) len_nxt = len_r + 3'd1;
    end
  end

  // addressing mode classification at line end
  always_comb begin
    logic sml, mid, single, imm, ind, com;
    sml    = !st_r.acc[16] && (st_r.acc[15:8] == 8'd0);
    mid    = !st_r.acc[16] && (st_r.acc[15:8] != 8'd0);
    imm    = st_r.marks.immed;
    ind    = st_r.marks.indir;
    com    = st_r.marks.comma;
    single = (st_r.phase == PH_LEAD) || (st_r.phase == PH_MNEM) || (st_r.phase == PH_GAP)
          || (st_r.phase == PH_SWITCH && !st_r.marks.pass2);
    rec.letters = letters_r;
    rec.len_ok  = (len_r == LEN_KEY);
    rec.operand = st_r.acc[15:0];
    rec.syn_err = 1'b0;
    rec.col     = alo_pkg::COL_NONE;
    rec.size    = 2'd0;
    if (single) begin
      rec.col  = alo_pkg::COL_IMP;
      rec.size = 2'd1;
    end else if (imm && !ind && !com && sml) begin
      rec.col  = alo_pkg::COL_IMM;
      rec.size = 2'd2;
    end else if (!ind && !imm && !com && sml) begin
      rec.col  = alo_pkg::COL_ZP;
      rec.size = 2'd2;
    end else if (!ind && !imm && com && sml) begin
      rec.size = 2'd2;
      if (st_r.marks.xreg) rec.col = alo_pkg::COL_ZPX;
      else if (st_r.marks.yreg) rec.col = alo_pkg::COL_ZPY;
    end else if (!ind && !imm && !com && mid) begin
      rec.col  = alo_pkg::COL_ABS;
      rec.size = 2'd3;
    end else if (!ind && !imm && com && mid) begin
      rec.size = 2'd3;
      if (st_r.marks.xreg) rec.col = alo_pkg::COL_ABX;
      else if (st_r.marks.yreg) rec.col = alo_pkg::COL_ABY;
    end else if (st_r.marks.idxind && !imm && com && sml) begin
      rec.size = 2'd2;
      if (st_r.marks.xreg) rec.col = alo_pkg::COL_IDX;
    end else if (st_r.marks.indidx && !imm && com && sml) begin
      rec.size = 2'd2;
      if (st_r.marks.yreg) rec.col = alo_pkg::COL_IDY;
    end else if (ind && !com && !imm) begin
      rec.col  = alo_pkg::COL_IND;
      rec.size = 2'd3;
    end else begin
      rec.syn_err = 1'b1;
    end
  end

  assign rec_push = char_valid && line_end;

  // line state, cleared after every line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '{phase: PH_LEAD, marks: '0, acc: '0};
      letters_r <= '0;
      len_r     <= '0;
    end else if (char_valid) begin
      if (line_end) begin
        st_r      <= '{phase: PH_LEAD, marks: '0, acc: '0};
        letters_r <= '0;
        len_r     <= '0;
      end else begin
        st_r      <= st_nxt;
        letters_r <= letters_nxt;
        len_r     <= len_nxt;
      end
    end
  end

endmodule

FILE: hw/rtl/alo_queue.sv
`include "assembly_line_to_opcode_core_defines.svh"

module alo_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = alo_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]  count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == CntW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = slot_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wr_ptr_r] <= wr_data;
  end

  `ALO_ASSERT_IMP(a_no_write_when_full, clk, rst_n, full, !wr_en, "write into full queue")

endmodule

FILE: hw/rtl/alo_back.sv
`include "assembly_line_to_opcode_core_defines.svh"

module alo_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [15:0]        cfg_start_address,
  input  logic               rec_valid,
  input  alo_pkg::line_rec_t rec,
  output logic               rec_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [15:0]        out_write_address,
  output logic [7:0]         out_write_byte,
  output logic               out_write_valid,
  output logic [1:0]         out_error_code,
  output logic [15:0]        out_next_location,
  output logic               out_last
);

  logic [15:0]   loc_r;
  logic          job_valid_r;
  logic [1:0]    beat_r;
  logic [15:0]   job_loc_r;
  logic [7:0]    job_opc_r;
  logic [15:0]   job_operand_r;
  logic [1:0]    job_size_r;
  alo_pkg::err_t job_err_r;

  logic          hit;
  logic [7:0]    opc;
  alo_pkg::err_t err_nxt;
  logic          last_beat, take, load;

  // opcode lookup: parallel key compare, then the mode column
  always_comb begin
    hit = 1'b0;
    opc = alo_pkg::OPC_NONE;
    for (int i = 0; i < alo_pkg::MNEMONIC_COUNT; i++) begin
      if (rec.letters == alo_pkg::MNEM_KEYS[i]) begin
        hit = 1'b1;
        if (rec.col < 4'(alo_pkg::MODE_COLUMNS)) opc = alo_pkg::OPCODE_TABLE[i][rec.col];
      end
    end
  end

  // error for the incoming line
  always_comb begin
    if (rec.syn_err) begin
      err_nxt = alo_pkg::ERR_SYNTAX;
    end else if (!rec.len_ok || !hit || opc == alo_pkg::OPC_NONE) begin
      err_nxt = alo_pkg::ERR_OPCODE;
    end else if ((rec.size == 2'd2 && loc_r > alo_pkg::LOC_MAX_2B)
              || (rec.size == 2'd3 && loc_r > alo_pkg::LOC_MAX_3B)) begin
      err_nxt = alo_pkg::ERR_MEMORY;
    end else begin
      err_nxt = alo_pkg::ERR_NONE;
    end
  end

  assign last_beat = (job_err_r != alo_pkg::ERR_NONE) || (beat_r == job_size_r - 2'd1);
  assign take      = job_valid_r && out_pop;
  assign load      = rec_valid && (!job_valid_r || (take && last_beat));
  assign rec_pop   = load;

  // job control and location counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      beat_r      <= '0;
      loc_r       <= '0;
    end else begin
      if (load) begin
        job_valid_r <= 1'b1;
        beat_r      <= '0;
      end else if (take && last_beat) begin
        job_valid_r <= 1'b0;
      end else if (take) begin
        beat_r <= beat_r + 2'd1;
      end
      if (cfg_write_en) begin
        loc_r <= cfg_start_address;
      end else if (load && err_nxt == alo_pkg::ERR_NONE) begin
        loc_r <= loc_r + {14'd0, rec.size};
      end
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    if (load) begin
      job_loc_r     <= loc_r;
      job_opc_r     <= opc;
      job_operand_r <= rec.operand;
      job_size_r    <= rec.size;
      job_err_r     <= err_nxt;
    end
  end

  // result beat from the current job
  always_comb begin
    out_empty = !job_valid_r;
    if (job_err_r != alo_pkg::ERR_NONE) begin
      out_write_address = '0;
      out_write_byte    = '0;
      out_write_valid   = 1'b0;
      out_next_location = job_loc_r;
    end else begin
      out_write_address = job_loc_r + {14'd0, beat_r};
      out_write_valid   = 1'b1;
      out_next_location = job_loc_r + {14'd0, job_size_r};
      case (beat_r)
        2'd0:    out_write_byte = job_opc_r;
        2'd1:    out_write_byte = job_operand_r[7:0];
        default: out_write_byte = job_operand_r[15:8];
      endcase
    end
    out_error_code = job_err_r;
    out_last       = last_beat;
  end

  `ALO_ASSERT_IMP(a_beat_in_size, clk, rst_n, job_valid_r && (job_err_r == alo_pkg::ERR_NONE), (job_size_r != 2'd0) && (beat_r < job_size_r), "beat outside instruction size")
  `ALO_ASSERT_IMP(a_err_single_beat, clk, rst_n, job_valid_r && (job_err_r != alo_pkg::ERR_NONE), beat_r == 2'd0, "error job with more than one beat")
  `ALO_ASSERT_NXT(a_loc_follows_job, clk, rst_n, load && !cfg_write_en, (loc_r == job_loc_r + ((job_err_r == alo_pkg::ERR_NONE) ? {14'd0, job_size_r} : 16'd0)), "location not advanced by loaded job")

endmodule

FILE: hw/rtl/assembly_line_to_opcode_core.sv
// 6502 line assembler, one source character per beat.
// Input channel: in_char_code is taken when in_push is high and in_full low.
// A NUL or line feed ends the line; other characters only update the parser.
// Result channel: while out_empty is low the oldest result sits on the out_
// ports and leaves when out_pop is high. A good line gives one to three beats
// (opcode, low byte, high byte) with write_valid set; a bad line gives one
// beat with error_code set. out_last marks the line's final beat.
// Throughput: one character per cycle while in_full is low; results leave at
// one beat per cycle while out_pop is high, set by the single emitter job
// register. A queue of QUEUE_DEPTH classified lines sits between parser and
// emitter, so a stalled receiver holds the parser only once that queue is
// full (in_full then rises).
// cfg_write_en loads cfg_start_address as the assembly location; write it
// only while no line is in flight.
// Reset (synchronous, rst_n low) clears the parser, the queue and the
// emitter and sets the location to 0.
module assembly_line_to_opcode_core #(
  parameter int QUEUE_DEPTH = alo_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_start_address,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_code,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_write_address,
  output logic [7:0]  out_write_byte,
  output logic        out_write_valid,
  output logic [1:0]  out_error_code,
  output logic [15:0] out_next_location,
  output logic        out_last
);

  localparam int RecW = $bits(alo_pkg::line_rec_t);

  logic               q_full, q_empty, q_push, q_pop;
  alo_pkg::line_rec_t front_rec, back_rec;
  logic [RecW-1:0]    q_rd_data;

  assign in_full  = q_full;
  assign back_rec = alo_pkg::line_rec_t'(q_rd_data);

  // parser and classifier
  alo_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (in_push && !q_full),
    .char_code  (in_char_code),
    .rec_push   (q_push),
    .rec        (front_rec)
  );

  // classified line queue
  alo_queue #(
    .WIDTH (RecW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (front_rec),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // opcode lookup and byte emitter
  alo_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_start_address (cfg_start_address),
    .rec_valid         (!q_empty),
    .rec               (back_rec),
    .rec_pop           (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_write_address (out_write_address),
    .out_write_byte    (out_write_byte),
    .out_write_valid   (out_write_valid),
    .out_error_code    (out_error_code),
    .out_next_location (out_next_location),
    .out_last          (out_last)
  );

endmodule

FILE: verif/alo_line_checker.sv
module alo_line_checker
  import alo_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_start_address,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_char_code,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [15:0] out_write_address,
  input  logic [7:0]  out_write_byte,
  input  logic        out_write_valid,
  input  logic [1:0]  out_error_code,
  input  logic [15:0] out_next_location,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // operand and syntax flags gathered while a line is scanned
  localparam logic [15:0] F_IMPLIED  = 16'h0001;
  localparam logic [15:0] F_IMMED    = 16'h0002;
  localparam logic [15:0] F_HEX      = 16'h0004;
  localparam logic [15:0] F_BIN      = 16'h0008;
  localparam logic [15:0] F_DEC      = 16'h0010;
  localparam logic [15:0] F_OPEN     = 16'h0020;
  localparam logic [15:0] F_COMMA    = 16'h0040;
  localparam logic [15:0] F_INDIRECT = 16'h0080;
  localparam logic [15:0] F_PRE_X    = 16'h0100;
  localparam logic [15:0] F_POST_Y   = 16'h0200;
  localparam logic [15:0] F_REG_Y    = 16'h0400;
  localparam logic [15:0] F_REG_X    = 16'h0800;
  localparam logic [15:0] F_SECOND   = 16'h1000;
  localparam logic [15:0] F_STOP     = 16'h2000;
  localparam logic [15:0] BRACKETS   = F_OPEN | F_INDIRECT;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;

  typedef enum logic [2:0] {
    SCAN_LEAD, SCAN_WORD, SCAN_GAP, SCAN_MARK,
    SCAN_SKIP, SCAN_VALUE, SCAN_INDEX, SCAN_TAIL
  } scan_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  data;
    logic        valid;
    err_t        err;
    logic [15:0] next_loc;
    logic        last;
  } asm_beat_t;

  logic [15:0] loc;
  logic [23:0] word;
  logic [2:0]  word_len;
  logic [16:0] value;
  logic [15:0] flags;
  scan_t       scan;
  asm_beat_t   beats_due[$];

  task automatic clear_line();
    word = '0;
    word_len = '0;
    value = '0;
    flags = '0;
    scan = SCAN_LEAD;
  endtask

  // mnemonic letters, folded to upper case, length saturates at four
  task automatic take_letter(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (word_len < 3) word[23 - 8 * int'(word_len) -: 8] = u;
    if (word_len < 4) word_len++;
  endtask

  // digits of the chosen base until the first foreign character
  task automatic take_digit(input logic [7:0] c);
    int unsigned radix, d;
    logic [31:0] nxt;
    if ((flags & F_STOP) != 0) return;
    if ((flags & F_DEC) != 0) radix = 10;
    else if ((flags & F_BIN) != 0) radix = 2;
    else if ((flags & F_HEX) != 0) radix = 16;
    else return;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "z") d = c - "a" + 10;
    else if (c >= "A" && c <= "Z") d = c - "A" + 10;
    else d = 99;
    if (d >= radix) begin
      flags |= F_STOP;
      return;
    end
    nxt = value[15:0] * radix + d;
    value = {value[16] | (nxt > 32'hFFFF), nxt[15:0]};
  endtask

  function automatic scan_t resume_scan();
    return ((flags & F_SECOND) != 0) ? SCAN_INDEX : SCAN_VALUE;
  endfunction

  task automatic read_index(input logic [7:0] c);
    if (c == "X" || c == "x") flags |= F_REG_X;
    if (c == "Y" || c == "y") flags |= F_REG_Y;
    scan = SCAN_TAIL;
  endtask

  task automatic scan_mark(input logic [7:0] c);
    if (c == "#") begin
      flags |= F_IMMED | F_HEX;
      scan = SCAN_SKIP;
    end else if (c == "$") begin
      flags |= F_HEX;
      scan = resume_scan();
    end else if (c == "%") begin
      flags |= F_BIN;
      scan = resume_scan();
    end else if (c == ",") begin
      if ((flags & BRACKETS) == BRACKETS) flags |= F_PRE_X;
      if ((flags & BRACKETS) == F_INDIRECT) flags |= F_POST_Y;
      flags |= F_COMMA;
      scan = resume_scan();
    end else begin
      flags |= F_DEC;
      if ((flags & F_SECOND) != 0) begin
        read_index(c);
      end else begin
        scan = SCAN_VALUE;
        take_digit(c);
      end
    end
  endtask

  task automatic scan_entry(input logic [7:0] c);
    if (c == "(") begin
      flags |= F_OPEN | F_INDIRECT;
      scan = SCAN_MARK;
    end else if (c == ")") begin
      flags &= ~F_OPEN;
      scan = SCAN_MARK;
    end else begin
      scan_mark(c);
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    case (scan)
      SCAN_LEAD: begin
        if (c != " ") begin
          take_letter(c);
          scan = SCAN_WORD;
        end
      end
      SCAN_WORD: begin
        if (c == " ") scan = SCAN_GAP;
        else take_letter(c);
      end
      SCAN_GAP: begin
        if (c != " ") scan_entry(c);
      end
      SCAN_MARK: scan_mark(c);
      SCAN_SKIP: scan = resume_scan();
      SCAN_VALUE: begin
        if (c == "," || c == ")") begin
          flags |= F_SECOND;
          scan_entry(c);
        end else begin
          take_digit(c);
        end
      end
      SCAN_INDEX: read_index(c);
      default: ;
    endcase
  endtask

  function automatic logic [7:0] opcode_of(input col_t col);
    if (word_len != 3) return OPC_NONE;
    for (int i = 0; i < MNEMONIC_COUNT; i++) begin
      if (MNEM_KEYS[i] == word) return OPCODE_TABLE[i][int'(col)];
    end
    return OPC_NONE;
  endfunction

  // classify the finished line and queue its result beats
  task automatic close_line();
    logic [15:0] f, lo, nxt;
    logic over, fits, wide, imm, ind, com;
    col_t col;
    int unsigned len;
    err_t err;
    logic [7:0] opc;
    asm_beat_t b;
    f = flags;
    lo = value[15:0];
    over = value[16];
    fits = !over && lo < 16'd256;
    wide = !over && lo > 16'd255;
    imm = (f & F_IMMED) != 0;
    ind = (f & F_INDIRECT) != 0;
    com = (f & F_COMMA) != 0;
    col = COL_NONE;
    len = 0;
    err = ERR_NONE;
    if (scan <= SCAN_GAP || (scan == SCAN_MARK && (f & F_SECOND) == 0)) f |= F_IMPLIED;

    if ((f & F_IMPLIED) != 0) begin
      col = COL_IMP;
      len = 1;
    end else if (imm && !ind && !com && fits) begin
      col = COL_IMM;
      len = 2;
    end else if (!ind && !imm && !com && fits) begin
      col = COL_ZP;
      len = 2;
    end else if (!ind && !imm && com && fits) begin
      len = 2;
      if ((f & F_REG_X) != 0) col = COL_ZPX;
      else if ((f & F_REG_Y) != 0) col = COL_ZPY;
    end else if (!ind && !imm && !com && wide) begin
      col = COL_ABS;
      len = 3;
    end else if (!ind && !imm && com && wide) begin
      len = 3;
      if ((f & F_REG_X) != 0) col = COL_ABX;
      else if ((f & F_REG_Y) != 0) col = COL_ABY;
    end else if ((f & F_PRE_X) != 0 && !imm && com && fits) begin
      len = 2;
      if ((f & F_REG_X) != 0) col = COL_IDX;
    end else if ((f & F_POST_Y) != 0 && !imm && com && fits) begin
      len = 2;
      if ((f & F_REG_Y) != 0) col = COL_IDY;
    end else if (ind && !com && !imm) begin
      col = COL_IND;
      len = 3;
    end else begin
      err = ERR_SYNTAX;
    end

    opc = OPC_NONE;
    if (err == ERR_NONE) begin
      if (col != COL_NONE) opc = opcode_of(col);
      if (opc == OPC_NONE) err = ERR_OPCODE;
    end
    // instruction must fit below the top of memory
    if (err == ERR_NONE && ((len == 2 && loc > LOC_MAX_2B) || (len == 3 && loc > LOC_MAX_3B)))
      err = ERR_MEMORY;

    clear_line();
    if (err != ERR_NONE) begin
      b.addr = '0;
      b.data = '0;
      b.valid = 1'b0;
      b.err = err;
      b.next_loc = loc;
      b.last = 1'b1;
      beats_due.push_back(b);
    end else begin
      nxt = loc + 16'(len);
      for (int unsigned k = 0; k < len; k++) begin
        b.addr = loc + 16'(k);
        b.data = (k == 0) ? opc : (k == 1) ? lo[7:0] : lo[15:8];
        b.valid = 1'b1;
        b.err = ERR_NONE;
        b.next_loc = nxt;
        b.last = (k == len - 1);
        beats_due.push_back(b);
      end
      loc = nxt;
    end
  endtask

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      fail_count++;
    end
  endtask

  task automatic check_beat();
    asm_beat_t want;
    if (beats_due.size() == 0) begin
      $error("result beat with nothing expected: address %0h byte %0h",
             out_write_address, out_write_byte);
      fail_count++;
      return;
    end
    want = beats_due.pop_front();
    compare_field("write_address", want.addr, out_write_address);
    compare_field("write_byte", want.data, out_write_byte);
    compare_field("write_valid", want.valid, out_write_valid);
    compare_field("error_code", want.err, out_error_code);
    compare_field("next_location", want.next_loc, out_next_location);
    compare_field("last", want.last, out_last);
  endtask

  // watch config, input and result beats at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_line();
      loc = '0;
      beats_due.delete();
    end else begin
      if (out_pop && !out_empty) check_beat();
      if (cfg_write_en) loc = cfg_start_address;
      if (in_push && !in_full) begin
        if (in_char_code == CH_NUL || in_char_code == CH_LF) close_line();
        else take_char(in_char_code);
      end
    end
    pending = beats_due.size();
  end

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import alo_pkg::*;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam int SETTLE_CYCLES  = 8;
  localparam int STALL_CYCLES   = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_write_en = 1'b0;
  logic [15:0] cfg_start_address = '0;
  logic        in_push = 1'b0;
  logic [7:0]  in_char_code = '0;
  logic        out_pop = 1'b0;
  logic        in_full, out_empty;
  logic [15:0] out_write_address, out_next_location;
  logic [7:0]  out_write_byte;
  logic        out_write_valid, out_last;
  logic [1:0]  out_error_code;

  int fail_count;
  int pending;
  int chars_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  assembly_line_to_opcode_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_start_address (cfg_start_address),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_char_code      (in_char_code),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_write_address (out_write_address),
    .out_write_byte    (out_write_byte),
    .out_write_valid   (out_write_valid),
    .out_error_code    (out_error_code),
    .out_next_location (out_next_location),
    .out_last          (out_last)
  );

  alo_line_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_start_address (cfg_start_address),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_char_code      (in_char_code),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_write_address (out_write_address),
    .out_write_byte    (out_write_byte),
    .out_write_valid   (out_write_valid),
    .out_error_code    (out_error_code),
    .out_next_location (out_next_location),
    .out_last          (out_last),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // result side: random pops, or a long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (STALL_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // one character beat, random gaps before it
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (in_full) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(term);
  endtask

  function automatic logic [7:0] line_end();
    return ($urandom_range(2) == 0) ? CH_NUL : CH_LF;
  endfunction

  // stop offering and wait until every expected beat has left
  task automatic drain();
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_start(input logic [15:0] a);
    cfg_write_en <= 1'b1;
    cfg_start_address <= a;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // operand in hex, binary or decimal, random case
  function automatic string value_text(input int unsigned v);
    string t;
    case ($urandom_range(2))
      0: t = {"$", $sformatf("%0h", v)};
      1: t = {"%", $sformatf("%0b", v)};
      default: t = $sformatf("%0d", v);
    endcase
    if ($urandom_range(1) == 1) t = t.toupper();
    return t;
  endfunction

  function automatic string byte_text();
    return value_text($urandom_range(255));
  endfunction

  function automatic string word_text();
    if ($urandom_range(9) == 0) return value_text($urandom_range(32'h1FFFF, 32'h10000));
    return value_text($urandom_range(65535, 256));
  endfunction

  // a line for a valid mnemonic and mode with random content
  function automatic string good_line();
    int m, col;
    string s, ix, iy, pre;
    logic [7:0] ch;
    m = $urandom_range(MNEMONIC_COUNT - 1);
    do col = $urandom_range(MODE_COLUMNS - 1);
    while (OPCODE_TABLE[m][col] == OPC_NONE);
    s = ($urandom_range(3) == 0) ? " " : "";
    for (int k = 0; k < 3; k++) begin
      ch = MNEM_KEYS[m][23 - 8 * k -: 8];
      if ($urandom_range(3) == 0) ch = ch | 8'h20;
      s = $sformatf("%s%c", s, ch);
    end
    ix = ($urandom_range(1) == 1) ? "X" : "x";
    iy = ($urandom_range(1) == 1) ? "Y" : "y";
    pre = "$";
    if ($urandom_range(3) == 0) pre = $sformatf("%c", 8'($urandom_range(126, 33)));
    case (col)
      COL_IMM: s = {s, " #", pre, $sformatf("%0h", $urandom_range(255))};
      COL_ABS: s = {s, " ", word_text()};
      COL_ABX: s = {s, " ", word_text(), ",", ix};
      COL_ABY: s = {s, " ", word_text(), ",", iy};
      COL_ZP:  s = {s, " ", byte_text()};
      COL_ZPX: s = {s, " ", byte_text(), ",", ix};
      COL_ZPY: s = {s, " ", byte_text(), ",", iy};
      COL_IDX: s = {s, " (", byte_text(), ",", ix, ")"};
      COL_IDY: s = {s, " (", byte_text(), "),", iy};
      COL_IND: s = {s, " (", word_text(), ")"};
      default: if ($urandom_range(1) == 1) s = {s, " "};
    endcase
    return s;
  endfunction

  // valid line with one character replaced or the tail cut off
  function automatic string broken_line();
    string s;
    int p;
    s = good_line();
    p = $urandom_range(s.len() - 1);
    if ($urandom_range(1) == 1) s.putc(p, 8'($urandom_range(126, 32)));
    else s = s.substr(0, p);
    return s;
  endfunction

  task automatic send_noise();
    int n;
    n = $urandom_range(9);
    repeat (n) send_char(8'($urandom_range(255, 1)));
    send_char(line_end());
  endtask

  task automatic random_lines(input int quota);
    int first, r;
    first = chars_sent;
    while (chars_sent - first < quota) begin
      r = $urandom_range(99);
      if (r < 72) send_line(good_line(), line_end());
      else if (r < 88) send_line(broken_line(), line_end());
      else send_noise();
    end
  endtask

  initial begin
    send_idle_pct = 6;
    recv_idle_pct = 53;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_start(16'h0000);

    // directed lines: modes, number parsing and error paths
    send_line("", CH_LF);
    send_line("  inx", CH_NUL);
    send_line("LDAX #$12", CH_LF);
    send_line("lda #$1F", CH_LF);
    send_line("ADC %10110101", CH_LF);
    send_line("CMP 300", CH_LF);
    send_line("LDA $12G4", CH_LF);
    send_line("LDA 0x10", CH_NUL);
    send_line("LDA -5", CH_LF);
    send_line("STA ,X", CH_LF);
    send_line("JMP ()", CH_LF);
    send_line("LDA ($20),Y", CH_LF);
    send_line("sta ($20,x)", CH_LF);
    send_line("JMP ($1234)", CH_LF);
    send_line("JMP ($12)%", CH_LF);
    send_line("LDA #", CH_NUL);
    send_line("LDX $12,X", CH_LF);
    send_line("LDA $1234,", CH_LF);
    send_line("LDA ($12),X", CH_LF);
    send_line("ADC $12345", CH_LF);
    send_line("STA $1234,Y", CH_LF);
    send_line("BNE $F0", CH_LF);
    send_line("LDY $10,X", CH_NUL);

    // top of memory: a three-byte line that ends at the top and wraps to zero
    drain();
    write_start(16'hFFFD);
    send_line("LDA $1234", CH_LF);
    send_line("LDA $12", CH_LF);
    send_line("JSR $8000", CH_LF);
    send_line("LDA $12", CH_LF);
    send_line("NOP", CH_LF);
    send_line("RTS", CH_NUL);

    // sender busy, receiver slow, with one long hold-off
    drain();
    write_start(16'hFFF0);
    hold_req = 1'b1;
    repeat (12) send_line(good_line(), line_end());
    random_lines(25);

    // sender slow, receiver busy, with a full pause in between
    drain();
    write_start(16'($urandom_range(65535)));
    send_idle_pct = 53;
    recv_idle_pct = 6;
    random_lines(20);
    drain();
    random_lines(20);

    // no idling on either side
    drain();
    write_start(16'hFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_lines(25);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
